// File: sv/pts_pkg.sv
// Shared types, codes and constants of the periodic task slot scheduler.
package pts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int KEY_W = 16;
  localparam int SLOT_IDX_W = 4;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_DISP = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_KEY   = 3'd2,
    ST_DUE       = 3'd3,
    ST_NONE_DUE  = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSTALL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] countdown;
    logic [KEY_W-1:0] period;
    logic             due;
  } slot_t;

  typedef struct packed {
    action_t          action;
    logic [KEY_W-1:0] task_key;
    logic [KEY_W-1:0] task_period;
    logic [KEY_W-1:0] start_delay;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [KEY_W-1:0]      due_key;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  last_of_run;
  } res_t;

endpackage

// File: sv/pts_cell.sv
// One task slot of the rotating slot chain.
module pts_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  pts_pkg::slot_t din,
  output pts_pkg::slot_t dout
);

  pts_pkg::slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= din;
    end
  end

  assign dout = slot;

endmodule

// File: sv/pts_ctrl.sv
// Sequencer that works on the head slot of the chain and builds the result beats.
module pts_ctrl #(
  parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  pts_pkg::req_t  req_in,
  input  pts_pkg::slot_t head,
  output pts_pkg::slot_t tail,
  output logic           shift,
  output logic           res_valid,
  input  logic           res_ready,
  output pts_pkg::res_t  res
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  function automatic logic [pts_pkg::SLOT_IDX_W-1:0] to_slot(input logic [IDX_W-1:0] v);
    logic [IDX_W+pts_pkg::SLOT_IDX_W-1:0] w;
    w = {{pts_pkg::SLOT_IDX_W{1'b0}}, v};
    return w[pts_pkg::SLOT_IDX_W-1:0];
  endfunction

  pts_pkg::state_t state, state_next;
  pts_pkg::req_t req, req_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic found, found_next;
  logic [IDX_W-1:0] first, first_next;
  logic free_ok, free_ok_next;
  logic [IDX_W-1:0] free_idx, free_idx_next;
  logic have_held, have_held_next;
  logic [pts_pkg::KEY_W-1:0] held_key, held_key_next;
  logic [IDX_W-1:0] held_idx, held_idx_next;
  logic [pts_pkg::CNT_W-1:0] cnt, cnt_next;
  logic out_valid;
  pts_pkg::res_t out_res, res_next;
  logic out_load, out_can, step;
  pts_pkg::slot_t proc;

  assign out_can = !out_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req <= req_next;
    idx <= idx_next;
    found <= found_next;
    first <= first_next;
    free_ok <= free_ok_next;
    free_idx <= free_idx_next;
    have_held <= have_held_next;
    held_key <= held_key_next;
    held_idx <= held_idx_next;
    cnt <= cnt_next;
    if (out_load) begin
      out_res <= res_next;
    end
  end

  always_comb begin
    state_next = state;
    req_next = req;
    idx_next = idx;
    found_next = found;
    first_next = first;
    free_ok_next = free_ok;
    free_idx_next = free_idx;
    have_held_next = have_held;
    held_key_next = held_key;
    held_idx_next = held_idx;
    cnt_next = cnt;
    out_load = 1'b0;
    res_next = '0;
    shift = 1'b0;
    step = 1'b0;
    proc = head;
    req_ready = (state == pts_pkg::S_IDLE);

    unique case (state)
      pts_pkg::S_IDLE: begin
        if (req_valid) begin
          req_next = req_in;
          idx_next = '0;
          found_next = 1'b0;
          first_next = '0;
          free_ok_next = 1'b0;
          free_idx_next = '0;
          have_held_next = 1'b0;
          cnt_next = '0;
          if ((req_in.action == pts_pkg::ACT_SET || req_in.action == pts_pkg::ACT_DEL)
              && req_in.task_key == '0) begin
            state_next = pts_pkg::S_FINISH;
          end else begin
            state_next = pts_pkg::S_SCAN;
          end
        end
      end

      pts_pkg::S_SCAN: begin
        step = 1'b1;
        unique case (req.action)
          pts_pkg::ACT_TICK: begin
            if (head.key != '0) begin
              if (head.countdown <= 16'd1) begin
                proc.due = 1'b1;
                proc.countdown = head.period;
              end else begin
                proc.countdown = head.countdown - 16'd1;
              end
            end
          end
          pts_pkg::ACT_SET: begin
            if (head.key == req.task_key) begin
              proc.countdown = req.start_delay;
              proc.period = req.task_period;
              proc.due = 1'b0;
              if (!found) begin
                first_next = idx;
              end
              found_next = 1'b1;
            end else if (head.key == '0 && !free_ok) begin
              free_ok_next = 1'b1;
              free_idx_next = idx;
            end
          end
          pts_pkg::ACT_DEL: begin
            if (head.key == req.task_key) begin
              proc = '0;
              if (!found) begin
                first_next = idx;
              end
              found_next = 1'b1;
            end
          end
          pts_pkg::ACT_DISP: begin
            if (head.due && cnt < pts_pkg::CNT_W'(pts_pkg::MAX_RESULTS)) begin
              if (have_held && !out_can) begin
                step = 1'b0;
              end else begin
                if (have_held) begin
                  out_load = 1'b1;
                  res_next.status = pts_pkg::ST_DUE;
                  res_next.due_key = held_key;
                  res_next.slot_index = to_slot(held_idx);
                  res_next.last_of_run = 1'b0;
                end
                have_held_next = 1'b1;
                held_key_next = head.key;
                held_idx_next = idx;
                cnt_next = cnt + 1'b1;
                proc.due = 1'b0;
                if (head.period == '0) begin
                  proc = '0;
                end
              end
            end
          end
          default: begin
          end
        endcase
        if (step) begin
          shift = 1'b1;
          if (idx == LAST_IDX) begin
            idx_next = '0;
            if (req.action == pts_pkg::ACT_SET && !found_next && free_ok_next) begin
              state_next = pts_pkg::S_INSTALL;
            end else begin
              state_next = pts_pkg::S_FINISH;
            end
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end

      pts_pkg::S_INSTALL: begin
        if (idx == free_idx) begin
          proc.key = req.task_key;
          proc.countdown = req.start_delay;
          proc.period = req.task_period;
          proc.due = 1'b0;
        end
        shift = 1'b1;
        if (idx == LAST_IDX) begin
          idx_next = '0;
          state_next = pts_pkg::S_FINISH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      pts_pkg::S_FINISH: begin
        if (out_can) begin
          out_load = 1'b1;
          state_next = pts_pkg::S_IDLE;
          res_next.last_of_run = 1'b1;
          res_next.status = pts_pkg::ST_ACCEPTED;
          unique case (req.action)
            pts_pkg::ACT_TICK: begin
              res_next.status = pts_pkg::ST_ACCEPTED;
            end
            pts_pkg::ACT_SET: begin
              if (req.task_key == '0) begin
                res_next.status = pts_pkg::ST_BAD_KEY;
              end else if (found) begin
                res_next.slot_index = to_slot(first);
              end else if (free_ok) begin
                res_next.slot_index = to_slot(free_idx);
              end else begin
                res_next.status = pts_pkg::ST_FULL;
              end
            end
            pts_pkg::ACT_DEL: begin
              if (req.task_key == '0) begin
                res_next.status = pts_pkg::ST_BAD_KEY;
              end else if (found) begin
                res_next.slot_index = to_slot(first);
              end else begin
                res_next.status = pts_pkg::ST_NOT_FOUND;
              end
            end
            pts_pkg::ACT_DISP: begin
              if (have_held) begin
                res_next.status = pts_pkg::ST_DUE;
                res_next.due_key = held_key;
                res_next.slot_index = to_slot(held_idx);
              end else begin
                res_next.status = pts_pkg::ST_NONE_DUE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_next = pts_pkg::S_IDLE;
      end
    endcase
  end

  assign tail = proc;
  assign res_valid = out_valid;
  assign res = out_res;

endmodule

// File: sv/periodic_task_slot_scheduler.sv
// Top level of the periodic task slot scheduler: slot chain and sequencer.
//
//   channel   dir  tdata                                    tuser    tlast
//   s_axis    in   task_key, task_period, start_delay       action   -
//   m_axis    out  status, due_key, slot_index, zero pad    -        last_of_run
//
// The slots sit in a ring of cells that rotates by one slot per cycle during a pass,
// except while a dispatch holds it still; a pass visits all TASK_SLOTS slots once.
// Tick, delete and dispatch make one pass; a set that installs a new key needs a second
// pass to write it into the free slot; a set or delete with key 0 makes no pass.
// A dispatch holds the ring still while its output register is full and not taken.
// Synchronous reset frees every slot at once; no clearing pass is needed.
module periodic_task_slot_scheduler #(
  parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // task_key, task_period, start_delay
  input  logic [1:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // status, due_key, slot_index, one zero bit
  output logic        m_axis_tlast
);

  pts_pkg::slot_t chain [TASK_SLOTS];
  pts_pkg::slot_t tail;
  pts_pkg::req_t req_in;
  pts_pkg::res_t res;
  logic shift;

  assign req_in.action = pts_pkg::action_t'(s_axis_tuser);
  assign req_in.task_key = s_axis_tdata[15:0];
  assign req_in.task_period = s_axis_tdata[31:16];
  assign req_in.start_delay = s_axis_tdata[47:32];

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    if (i == TASK_SLOTS - 1) begin : g_last
      pts_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .din   (tail),
        .dout  (chain[i])
      );
    end else begin : g_mid
      pts_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .din   (chain[i+1]),
        .dout  (chain[i])
      );
    end
  end

  pts_ctrl #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_in    (req_in),
    .head      (chain[0]),
    .tail      (tail),
    .shift     (shift),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {1'b0, res.slot_index, res.due_key, res.status};
  assign m_axis_tlast = res.last_of_run;

endmodule

// File: sv/pts_checker.sv
// Port checker for the periodic task slot scheduler, bound to the top level.
module pts_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Output beat present right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("Stalled output beat changed.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(pts_pkg::ST_NOT_FOUND))
    else $error("Status code out of range.");

  a_key_only_due: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'(pts_pkg::ST_DUE) |-> m_axis_tdata[18:3] == '0)
    else $error("Key reported on a beat that is not a due task.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'(pts_pkg::ST_DUE) |-> m_axis_tlast)
    else $error("Single-beat answer not marked last.");

endmodule

bind periodic_task_slot_scheduler pts_checker u_pts_checker (.*);

// File: test/periodic_task_slot_scheduler_checker.sv
// Checker for the periodic task slot scheduler: predicts every result beat and compares it.
module periodic_task_slot_scheduler_checker #(
  parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // task_key, task_period, start_delay
  input  logic [1:0]  s_axis_tuser,  // action
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,  // status, due_key, slot_index, one zero bit
  input  logic        m_axis_tlast,
  output int          mismatches,
  output int          pending
);
  import pts_pkg::*;

  logic [KEY_W-1:0] slot_key       [TASK_SLOTS];
  logic [KEY_W-1:0] slot_countdown [TASK_SLOTS];
  logic [KEY_W-1:0] slot_period    [TASK_SLOTS];
  logic             slot_due       [TASK_SLOTS];

  res_t awaited_answers[$];
  int   mismatch_count = 0;
  int   pending_count = 0;

  assign mismatches = mismatch_count;
  assign pending = pending_count;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
    mismatch_count++;
  endtask

  task automatic free_slot(int s);
    slot_key[s] = '0;
    slot_countdown[s] = '0;
    slot_period[s] = '0;
    slot_due[s] = 1'b0;
  endtask

  task automatic add_answer(status_t st, logic [KEY_W-1:0] key, int s, logic last);
    res_t r;
    r.status = st;
    r.due_key = key;
    r.slot_index = s[SLOT_IDX_W-1:0];
    r.last_of_run = last;
    awaited_answers.push_back(r);
  endtask

  task automatic schedule_request(action_t act, logic [KEY_W-1:0] key,
                                  logic [KEY_W-1:0] period, logic [KEY_W-1:0] delay);
    int s;
    int first;
    int due_total;
    int sent;
    bit found;
    bit placed;
    found = 1'b0;
    placed = 1'b0;
    first = 0;
    due_total = 0;
    sent = 0;
    case (act)
      ACT_TICK: begin
        for (s = 0; s < TASK_SLOTS; s++) begin
          if (slot_key[s] != '0) begin
            if (slot_countdown[s] <= 1) begin
              slot_due[s] = 1'b1;
              slot_countdown[s] = slot_period[s];
            end else begin
              slot_countdown[s] = slot_countdown[s] - 1'b1;
            end
          end
        end
        add_answer(ST_ACCEPTED, '0, 0, 1'b1);
      end
      ACT_SET: begin
        if (key == '0) begin
          add_answer(ST_BAD_KEY, '0, 0, 1'b1);
        end else begin
          for (s = 0; s < TASK_SLOTS; s++) begin
            if (slot_key[s] == key) begin
              slot_countdown[s] = delay;
              slot_period[s] = period;
              slot_due[s] = 1'b0;
              if (!found) first = s;
              found = 1'b1;
            end
          end
          if (found) begin
            add_answer(ST_ACCEPTED, '0, first, 1'b1);
          end else begin
            for (s = 0; s < TASK_SLOTS && !placed; s++) begin
              if (slot_key[s] == '0) begin
                slot_key[s] = key;
                slot_countdown[s] = delay;
                slot_period[s] = period;
                slot_due[s] = 1'b0;
                add_answer(ST_ACCEPTED, '0, s, 1'b1);
                placed = 1'b1;
              end
            end
            if (!placed) add_answer(ST_FULL, '0, 0, 1'b1);
          end
        end
      end
      ACT_DEL: begin
        if (key == '0) begin
          add_answer(ST_BAD_KEY, '0, 0, 1'b1);
        end else begin
          for (s = 0; s < TASK_SLOTS; s++) begin
            if (slot_key[s] == key) begin
              free_slot(s);
              if (!found) first = s;
              found = 1'b1;
            end
          end
          if (found) add_answer(ST_ACCEPTED, '0, first, 1'b1);
          else add_answer(ST_NOT_FOUND, '0, 0, 1'b1);
        end
      end
      default: begin
        for (s = 0; s < TASK_SLOTS; s++) begin
          if (slot_due[s]) due_total++;
        end
        if (due_total > MAX_RESULTS) due_total = MAX_RESULTS;
        if (due_total == 0) begin
          add_answer(ST_NONE_DUE, '0, 0, 1'b1);
        end else begin
          for (s = 0; s < TASK_SLOTS && sent < due_total; s++) begin
            if (slot_due[s]) begin
              sent++;
              add_answer(ST_DUE, slot_key[s], s, sent == due_total);
              slot_due[s] = 1'b0;
              if (slot_period[s] == '0) free_slot(s);
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_answer();
    res_t want;
    if (awaited_answers.size() == 0) begin
      report_mismatch("unexpected result beat", {7'b0, m_axis_tlast, m_axis_tdata}, 32'h0);
    end else begin
      want = awaited_answers.pop_front();
      if (m_axis_tdata[2:0] !== want.status)
        report_mismatch("status", 32'(m_axis_tdata[2:0]), 32'(want.status));
      if (m_axis_tdata[18:3] !== want.due_key)
        report_mismatch("due_key", 32'(m_axis_tdata[18:3]), 32'(want.due_key));
      if (m_axis_tdata[22:19] !== want.slot_index)
        report_mismatch("slot_index", 32'(m_axis_tdata[22:19]), 32'(want.slot_index));
      if (m_axis_tdata[23] !== 1'b0)
        report_mismatch("pad bit", 32'(m_axis_tdata[23]), 32'h0);
      if (m_axis_tlast !== want.last_of_run)
        report_mismatch("last_of_run", 32'(m_axis_tlast), 32'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TASK_SLOTS; s++) free_slot(s);
      awaited_answers.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_answer();
      if (s_axis_tvalid && s_axis_tready)
        schedule_request(action_t'(s_axis_tuser), s_axis_tdata[15:0],
                         s_axis_tdata[31:16], s_axis_tdata[47:32]);
    end
    pending_count = awaited_answers.size();
  end

endmodule

// File: test/periodic_task_slot_scheduler_test.sv
// Testbench top of the periodic task slot scheduler: stimulus, idling, watchdog and verdict.
module periodic_task_slot_scheduler_test;
  import pts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // task_key, task_period, start_delay
  logic [1:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // status, due_key, slot_index, one zero bit
  logic        m_axis_tlast;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  bit tx_steady = 1'b1;
  bit rx_steady = 1'b1;
  bit hold_request = 1'b0;

  periodic_task_slot_scheduler u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  periodic_task_slot_scheduler_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(action_t act, logic [15:0] key, logic [15:0] period,
                              logic [15:0] delay);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= {delay, period, key};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_answers();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return 16'h0000;
    if (r < 5) return 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 19);
    case (r)
      16: return 16'hFFFF;
      17: return 16'h8000;
      18: return 16'hAAAA;
      19: return 16'h5555;
      default: return 16'(r + 1);
    endcase
  endfunction

  function automatic logic [15:0] pick_span();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 4));
    if (r < 9) return 16'($urandom_range(5, 20));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_request();
    int r;
    action_t act;
    r = $urandom_range(0, 99);
    if (r < 35) act = ACT_TICK;
    else if (r < 65) act = ACT_SET;
    else if (r < 80) act = ACT_DEL;
    else act = ACT_DISP;
    send_request(act, pick_key(), pick_span(), pick_span());
  endtask

  initial begin : receiver
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 16);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, zero keys and an unknown key.
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_SET, 16'h0000, 16'h0005, 16'h0005);
    send_request(ACT_DEL, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_request(ACT_DEL, 16'h1234, 16'h0000, 16'h0000);
    // Extreme values, a one-shot task and short periods.
    send_request(ACT_SET, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(ACT_SET, 16'h0001, 16'h0000, 16'h0000);
    send_request(ACT_SET, 16'h8000, 16'h0001, 16'h0001);
    send_request(ACT_SET, 16'h5555, 16'h0002, 16'h0003);
    send_request(ACT_SET, 16'hAAAA, 16'h0003, 16'h0002);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_SET, 16'h8000, 16'h0004, 16'h0000);
    send_request(ACT_DEL, 16'hFFFF, 16'h0000, 16'h0000);
    send_request(ACT_SET, 16'h0001, 16'h0002, 16'h0001);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    drain_answers();

    // Fill the table past its size, let everything fall due, then clear it.
    rx_steady = 1'b0;
    for (int i = 0; i < 18; i++) send_request(ACT_SET, 16'(16'h0100 + i), 16'(i % 3), 16'h0000);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_request(ACT_DISP, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 18; i++) send_request(ACT_DEL, 16'(16'h0100 + i), 16'h0000, 16'h0000);
    drain_answers();

    for (int p = 0; p < PHASES; p++) begin
      tx_steady = (p % 3 == 0);
      rx_steady = (p % 4 == 1);
      if (p == 4) hold_request <= 1'b1;
      repeat (PHASE_ITEMS) random_request();
      drain_answers();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
